FILE: sv/lpis_pkg.sv
// ----------------------------------------------------------------------------
// lpis_pkg
// Shared constants and types for the linear-probe identifier set.
// ----------------------------------------------------------------------------
package lpis_pkg;

    localparam int TABLE_SLOTS = 1024;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int ID_W        = 32;
    localparam int COUNT_W     = 11;
    localparam int STATUS_W    = 3;
    localparam int REQ_W       = 2;

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SLOTS - 1);

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;

    localparam logic [STATUS_W-1:0] STAT_DONE      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_PRESENT   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_INVALID   = 3'd4;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_REMOVE,
        OP_QUERY
    } op_t;

endpackage

FILE: sv/linear_probe_id_set_core.sv
// ----------------------------------------------------------------------------
// linear_probe_id_set_core
// Open-addressed identifier set with linear probing in one slot RAM.
// ----------------------------------------------------------------------------
// Probe: k slots are examined per request, k = 1..TABLE_SLOTS; a zero id
//   skips the probe (k = 0).
// Throughput: one request at a time, s_ready high only in idle; the single
//   RAM read port examines one slot per cycle; a held result stalls until m_ready.
// Reset: a clearing pass writes every slot to zero, with s_ready low.
module linear_probe_id_set_core
    import lpis_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [REQ_W-1:0]    s_req_type,
    input  logic [ID_W-1:0]     s_entity_id,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic                m_present,
    output logic [COUNT_W-1:0]  m_stored_count
);

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [SLOT_W-1:0]    cur_reg, cur_next;
    logic [SLOT_W-1:0]    n_reg, n_next;
    logic [SLOT_W-1:0]    clr_reg, clr_next;
    logic [COUNT_W-1:0]   cnt_reg, cnt_next;
    logic [STATUS_W-1:0]  rs_reg, rs_next;
    logic                 rp_reg, rp_next;
    logic                 mv_reg, mv_next;
    logic [STATUS_W-1:0]  ms_reg, ms_next;
    logic                 mp_reg, mp_next;
    logic [COUNT_W-1:0]   mc_reg, mc_next;

    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    logic [ID_W-1:0]      ram_wdata;
    logic [SLOT_W-1:0]    ram_raddr;
    logic [ID_W-1:0]      ram_rdata;

    logic                 hit;
    logic                 empty;
    logic                 lap_end;
    logic [SLOT_W-1:0]    cur_inc;

    lpis_ram #(
        .WIDTH (ID_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign hit     = (ram_rdata == id_reg);
    assign empty   = (ram_rdata == '0);
    assign lap_end = (n_reg == SLOT_LAST);
    assign cur_inc = (cur_reg == SLOT_LAST) ? '0 : cur_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
        end
        op_reg  <= op_next;
        id_reg  <= id_next;
        cur_reg <= cur_next;
        n_reg   <= n_next;
        rs_reg  <= rs_next;
        rp_reg  <= rp_next;
        ms_reg  <= ms_next;
        mp_reg  <= mp_next;
        mc_reg  <= mc_next;
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        id_next    = id_reg;
        cur_next   = cur_reg;
        n_next     = n_reg;
        clr_next   = clr_reg;
        cnt_next   = cnt_reg;
        rs_next    = rs_reg;
        rp_next    = rp_reg;
        mv_next    = mv_reg;
        ms_next    = ms_reg;
        mp_next    = mp_reg;
        mc_next    = mc_reg;
        ram_we     = 1'b0;
        ram_waddr  = cur_reg;
        ram_wdata  = '0;
        ram_raddr  = cur_reg;
        s_ready    = 1'b0;

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                if (clr_reg == SLOT_LAST) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                s_ready   = 1'b1;
                ram_raddr = s_entity_id[SLOT_W-1:0];
                if (s_valid) begin
                    id_next  = s_entity_id;
                    cur_next = s_entity_id[SLOT_W-1:0];
                    n_next   = '0;
                    unique case (s_req_type)
                        REQ_INSERT: op_next = OP_INSERT;
                        REQ_REMOVE: op_next = OP_REMOVE;
                        default:    op_next = OP_QUERY;
                    endcase
                    if (s_entity_id == '0) begin
                        rs_next    = STAT_INVALID;
                        rp_next    = 1'b0;
                        state_next = ST_RESP;
                    end else begin
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                // keep reading ahead; a stop discards the read in flight
                cur_next  = cur_inc;
                n_next    = n_reg + 1'b1;
                ram_raddr = cur_inc;
                unique case (op_reg)
                    OP_INSERT: begin
                        if (hit) begin
                            rs_next    = STAT_PRESENT;
                            rp_next    = 1'b1;
                            state_next = ST_RESP;
                        end else if (empty) begin
                            ram_we     = 1'b1;
                            ram_wdata  = id_reg;
                            cnt_next   = cnt_reg + 1'b1;
                            rs_next    = STAT_DONE;
                            rp_next    = 1'b1;
                            state_next = ST_RESP;
                        end else if (lap_end) begin
                            rs_next    = STAT_FULL;
                            rp_next    = 1'b0;
                            state_next = ST_RESP;
                        end
                    end
                    OP_REMOVE: begin
                        // first match in probe order is cleared to zero; a remove does not
                        // stop at an empty slot, only at a match or the end of the lap
                        if (hit) begin
                            ram_we     = 1'b1;
                            ram_wdata  = '0;
                            if (cnt_reg != '0) begin
                                cnt_next = cnt_reg - 1'b1;
                            end
                            rs_next    = STAT_DONE;
                            rp_next    = 1'b0;
                            state_next = ST_RESP;
                        end else if (lap_end) begin
                            rs_next    = STAT_NOT_FOUND;
                            rp_next    = 1'b0;
                            state_next = ST_RESP;
                        end
                    end
                    OP_QUERY: begin
                        if (hit) begin
                            rs_next    = STAT_DONE;
                            rp_next    = 1'b1;
                            state_next = ST_RESP;
                        end else if (empty || lap_end) begin
                            rs_next    = STAT_NOT_FOUND;
                            rp_next    = 1'b0;
                            state_next = ST_RESP;
                        end
                    end
                    default: begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_RESP: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    ms_next    = rs_reg;
                    mp_next    = rp_reg;
                    mc_next    = cnt_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid        = mv_reg;
    assign m_status       = ms_reg;
    assign m_present      = mp_reg;
    assign m_stored_count = mc_reg;

endmodule

FILE: sv/lpis_ram.sv
// ----------------------------------------------------------------------------
// lpis_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lpis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sim/tb_linear_probe_id_set_core.sv
// ----------------------------------------------------------------------------
// tb_linear_probe_id_set_core
// Self-checking bench for the linear-probe identifier set. A shadow slot
// table predicts status, presence and count for every request; results are
// checked in order. Stimulus covers zero ids, wrap-around chains, holes left
// by remove, a completely full table and random mixed traffic.
// ----------------------------------------------------------------------------
module tb_linear_probe_id_set_core
    import lpis_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [REQ_W-1:0] REQ_QUERY = REQ_W'(OP_QUERY);
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
    localparam int POOL_N = 40;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                present;
        logic [COUNT_W-1:0]  count;
    } id_result_t;

    class id_set_board;
        logic [ID_W-1:0]    shadow_slots [TABLE_SLOTS];
        logic [COUNT_W-1:0] shadow_count;
        id_result_t         due_results [$];
        int                 errors;
        int                 peak;
        int                 by_status [8];

        function new();
            foreach (shadow_slots[i]) shadow_slots[i] = '0;
            shadow_count = '0;
            errors = 0;
            peak = 0;
            foreach (by_status[i]) by_status[i] = 0;
        endfunction

        function int home_of(logic [ID_W-1:0] id);
            return int'(id % ID_W'(TABLE_SLOTS));
        endfunction

        // first slot that matches or is empty, at most one lap
        function bit stop_slot(logic [ID_W-1:0] id, output int where);
            int s;
            s = home_of(id);
            for (int n = 0; n < TABLE_SLOTS; n++) begin
                if (shadow_slots[s] == '0 || shadow_slots[s] == id) begin
                    where = s;
                    return 1'b1;
                end
                s = (s + 1) % TABLE_SLOTS;
            end
            where = 0;
            return 1'b0;
        endfunction

        function bit holds(logic [ID_W-1:0] id);
            int where;
            if (!stop_slot(id, where)) return 1'b0;
            return shadow_slots[where] == id;
        endfunction

        function logic [ID_W-1:0] held_id();
            int s;
            s = $urandom_range(TABLE_SLOTS - 1);
            for (int n = 0; n < TABLE_SLOTS; n++) begin
                if (shadow_slots[s] != '0) return shadow_slots[s];
                s = (s + 1) % TABLE_SLOTS;
            end
            return '0;
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic [ID_W-1:0] id);
            id_result_t r;
            int         where;
            int         s;
            r.present = 1'b0;
            if (id == '0) begin
                r.status = STAT_INVALID;
            end else if (req == REQ_INSERT) begin
                if (!stop_slot(id, where)) begin
                    r.status = STAT_FULL;
                end else if (shadow_slots[where] == id) begin
                    r.status = STAT_PRESENT;
                end else begin
                    shadow_slots[where] = id;
                    shadow_count = shadow_count + 1'b1;
                    r.status = STAT_DONE;
                end
                r.present = holds(id);
            end else if (req == REQ_REMOVE) begin
                // full scan, empty slots do not stop a remove
                r.status = STAT_NOT_FOUND;
                s = home_of(id);
                for (int n = 0; n < TABLE_SLOTS; n++) begin
                    if (shadow_slots[s] == id) begin
                        shadow_slots[s] = '0;
                        if (shadow_count != '0) shadow_count = shadow_count - 1'b1;
                        r.status = STAT_DONE;
                        break;
                    end
                    s = (s + 1) % TABLE_SLOTS;
                end
                r.present = holds(id);
            end else begin
                r.present = holds(id);
                r.status = r.present ? STAT_DONE : STAT_NOT_FOUND;
            end
            r.count = shadow_count;
            if (int'(shadow_count) > peak) peak = int'(shadow_count);
            by_status[r.status]++;
            due_results.push_back(r);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic present,
                                   logic [COUNT_W-1:0] count);
            id_result_t exp_r;
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result status %0d present %0d count %0d",
                         $realtime, status, present, count);
                errors++;
                return;
            end
            exp_r = due_results.pop_front();
            if (status !== exp_r.status) begin
                $display("%0t: status mismatch, expected %0d, got %0d",
                         $realtime, exp_r.status, status);
                errors++;
            end
            if (present !== exp_r.present) begin
                $display("%0t: present mismatch, expected %0d, got %0d",
                         $realtime, exp_r.present, present);
                errors++;
            end
            if (count !== exp_r.count) begin
                $display("%0t: stored_count mismatch, expected %0d, got %0d",
                         $realtime, exp_r.count, count);
                errors++;
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [REQ_W-1:0]    s_req_type = '0;
    logic [ID_W-1:0]     s_entity_id = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic                m_present;
    logic [COUNT_W-1:0]  m_stored_count;

    id_set_board board = new();
    bit          steady = 1'b0;
    logic [ID_W-1:0] key_pool [POOL_N];

    linear_probe_id_set_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_entity_id    (s_entity_id),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_present      (m_present),
        .m_stored_count (m_stored_count)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            board.check_result(m_status, m_present, m_stored_count);
        end
        m_ready <= steady || ($urandom_range(99) >= 6);
    end

    function automatic logic [ID_W-1:0] fresh_id();
        logic [ID_W-1:0] v;
        v = $urandom;
        while (v == '0) v = $urandom;
        return v;
    endfunction

    // ids crowded around the wrap point to build long chains
    function automatic logic [ID_W-1:0] crowded_id();
        logic [ID_W-1:0] v;
        v = $urandom;
        v[SLOT_W-1:0] = SLOT_W'((TABLE_SLOTS - 4 + $urandom_range(7)) % TABLE_SLOTS);
        if (v == '0) v = ID_W'(TABLE_SLOTS);
        return v;
    endfunction

    task automatic send_request(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] id);
        while (!steady && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_req_type  <= req;
        s_entity_id <= id;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        board.note_request(req, id);
    endtask

    initial begin
        int              r;
        logic [ID_W-1:0] id;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: zero id, extremes, wrap, holes, duplicate storage
        send_request(REQ_QUERY,  32'h0);
        send_request(REQ_INSERT, 32'h0);
        send_request(REQ_REMOVE, 32'h0);
        send_request(REQ_SPARE,  32'h0);
        send_request(REQ_QUERY,  32'hFFFF_FFFF);
        send_request(REQ_INSERT, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, ID_W'(2 * TABLE_SLOTS - 1));
        send_request(REQ_INSERT, ID_W'(TABLE_SLOTS));
        send_request(REQ_SPARE,  ID_W'(TABLE_SLOTS));
        send_request(REQ_REMOVE, ID_W'(2 * TABLE_SLOTS - 1));
        send_request(REQ_QUERY,  ID_W'(TABLE_SLOTS));
        send_request(REQ_INSERT, ID_W'(TABLE_SLOTS));
        send_request(REQ_REMOVE, ID_W'(TABLE_SLOTS));
        send_request(REQ_REMOVE, ID_W'(TABLE_SLOTS));
        send_request(REQ_REMOVE, ID_W'(TABLE_SLOTS));
        send_request(REQ_INSERT, 32'h1);
        send_request(REQ_QUERY,  32'h1);
        send_request(REQ_REMOVE, 32'hFFFF_FFFF);
        send_request(REQ_SPARE,  32'hFFFF_FFFF);
        send_request(REQ_INSERT, 32'h8000_0000);

        // mixed traffic on a small, crowded key pool
        foreach (key_pool[i]) key_pool[i] = (i < 24) ? crowded_id() : fresh_id();
        for (int i = 0; i < 450; i++) begin
            steady = (i >= 150 && i < 400);
            r = $urandom_range(99);
            id = ($urandom_range(9) == 0) ? fresh_id() : key_pool[$urandom_range(POOL_N - 1)];
            if (r < 3)       send_request(REQ_W'($urandom_range(3)), '0);
            else if (r < 45) send_request(REQ_INSERT, id);
            else if (r < 65) send_request(REQ_REMOVE, id);
            else if (r < 90) send_request(REQ_QUERY, id);
            else             send_request(REQ_SPARE, id);
        end
        steady = 1'b0;

        // fill every slot
        while (board.shadow_count != COUNT_W'(TABLE_SLOTS)) begin
            if ($urandom_range(9) == 0) send_request(REQ_QUERY, board.held_id());
            else                        send_request(REQ_INSERT, fresh_id());
        end

        // full table: rejects and full-lap misses
        for (int i = 0; i < 30; i++) begin
            case (i % 6)
                0: send_request(REQ_INSERT, fresh_id());
                1: send_request(REQ_INSERT, board.held_id());
                2: send_request(REQ_QUERY, fresh_id());
                3: send_request(REQ_REMOVE, fresh_id());
                4: send_request(REQ_SPARE, board.held_id());
                default: send_request(REQ_W'($urandom_range(3)), '0);
            endcase
        end

        // drain back down with mixed traffic
        for (int i = 0; i < 350; i++) begin
            r = $urandom_range(99);
            if (r < 55)      send_request(REQ_REMOVE, board.held_id());
            else if (r < 65) send_request(REQ_REMOVE, fresh_id());
            else if (r < 75) send_request(REQ_QUERY, board.held_id());
            else if (r < 82) send_request(REQ_SPARE, fresh_id());
            else if (r < 90) send_request(REQ_INSERT, fresh_id());
            else if (r < 97) send_request(REQ_INSERT, board.held_id());
            else             send_request(REQ_W'($urandom_range(3)), '0);
        end

        s_valid <= 1'b0;
        while (board.due_results.size() != 0) @(posedge aclk);
        repeat (TABLE_SLOTS + 8) @(posedge aclk);

        $display("Requests by outcome: %0d done, %0d duplicate, %0d missing, %0d full, %0d zero id",
                 board.by_status[STAT_DONE], board.by_status[STAT_PRESENT],
                 board.by_status[STAT_NOT_FOUND], board.by_status[STAT_FULL],
                 board.by_status[STAT_INVALID]);
        $display("Peak occupancy %0d of %0d slots, %0d check errors",
                 board.peak, TABLE_SLOTS, board.errors);
        if (board.errors == 0 && board.due_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("Timeout with %0d results outstanding", board.due_results.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: filelist.f
sv/lpis_pkg.sv
sv/lpis_ram.sv
sv/linear_probe_id_set_core.sv
sim/tb_linear_probe_id_set_core.sv
